>>> hw/rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion name failed");

// expression that must never be true outside reset
`define ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("never condition hit");

`endif

>>> hw/rtl/mahd_pkg.sv
package mahd_pkg;

  localparam logic [1:0] LAYER_RESERVED = 2'd0;
  localparam logic [1:0] LI_LAYER2      = 2'd1;
  localparam logic [1:0] MODE_JOINT     = 2'd1;
  localparam logic [1:0] MODE_MONO      = 2'd3;
  localparam logic [1:0] SF_RESERVED    = 2'd3;
  localparam logic [1:0] SF_48K         = 2'd1;
  localparam logic [1:0] SF_32K         = 2'd2;
  localparam logic [3:0] COL_MPEG25     = 4'd6;
  localparam logic [3:0] COL_MPEG1      = 4'd3;
  localparam logic [5:0] FULL_SUBBANDS  = 6'd32;

  localparam logic [1:0] ALLOC_SEL_A    = 2'd0;
  localparam logic [1:0] ALLOC_SEL_B    = 2'd1;
  localparam logic [1:0] ALLOC_SEL_C    = 2'd2;
  localparam logic [3:0] ALLOC_BASE_LOW = 4'd9;

  localparam logic [8:0] KBPS_TABLE [2][3][16] = '{
    '{ '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
         9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
       '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
         9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
       '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
         9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0} },
    '{ '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
         9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
       '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
         9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
       '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
         9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0} }
  };

  // rows: mpeg-2, mpeg-1, mpeg-2.5
  localparam logic [15:0] HZ_TABLE [3][4] = '{
    '{16'd22050, 16'd24000, 16'd16000, 16'd0},
    '{16'd44100, 16'd48000, 16'd32000, 16'd0},
    '{16'd11025, 16'd12000, 16'd8000,  16'd0}
  };

  localparam logic [6:0] MS_TABLE [3][9] = '{
    '{7'd17, 7'd16, 7'd24, 7'd9,  7'd8,  7'd12, 7'd0,  7'd0,  7'd0},
    '{7'd52, 7'd48, 7'd72, 7'd26, 7'd24, 7'd36, 7'd0,  7'd0,  7'd0},
    '{7'd26, 7'd24, 7'd36, 7'd26, 7'd24, 7'd36, 7'd52, 7'd48, 7'd72}
  };

  localparam logic [5:0] BOUND_TABLE [3][4] = '{
    '{6'd4, 6'd8, 6'd12, 6'd16},
    '{6'd4, 6'd8, 6'd12, 6'd16},
    '{6'd0, 6'd4, 6'd8,  6'd16}
  };

  typedef struct packed {
    logic        hdr_ok;
    logic [1:0]  li;
    logic        ver;
    logic [1:0]  sf;
    logic [1:0]  mode;
    logic [1:0]  mext;
    logic [8:0]  kbps;
    logic [15:0] hz;
    logic [6:0]  ms;
  } lookup_t;

  typedef struct packed {
    logic        hdr_ok;
    logic [8:0]  kbps;
    logic [15:0] hz;
    logic [6:0]  ms;
    logic [5:0]  limit;
    logic [5:0]  bound;
    logic [1:0]  sel;
    logic [3:0]  base;
  } alloc_t;

endpackage

>>> hw/rtl/mahd_lookup.sv
module mahd_lookup (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [31:0]            header_word_i,
  output logic                   valid_o,
  output mahd_pkg::lookup_t      stage_o
);

  logic              valid_q;
  mahd_pkg::lookup_t stage_d;
  mahd_pkg::lookup_t stage_q;
  logic              is25;
  logic [1:0]        lcode;
  logic [3:0]        bidx;
  logic [1:0]        hz_row;
  logic [3:0]        ms_col;

  always_comb begin
    is25  = ~header_word_i[20];
    lcode = header_word_i[18:17];
    bidx  = header_word_i[15:12];

    stage_d.hdr_ok = (lcode != mahd_pkg::LAYER_RESERVED);
    stage_d.li     = stage_d.hdr_ok ? (2'd3 - lcode) : 2'd0;
    stage_d.ver    = header_word_i[19];
    stage_d.sf     = header_word_i[11:10];
    stage_d.mode   = header_word_i[7:6];
    stage_d.mext   = header_word_i[5:4];

    hz_row = is25 ? 2'd2 : {1'b0, stage_d.ver};
    ms_col = (is25 ? mahd_pkg::COL_MPEG25 : (stage_d.ver ? mahd_pkg::COL_MPEG1 : 4'd0))
           + {2'd0, stage_d.sf};

    stage_d.kbps = mahd_pkg::KBPS_TABLE[stage_d.ver][stage_d.li][bidx];
    stage_d.hz   = mahd_pkg::HZ_TABLE[hz_row][stage_d.sf];
    stage_d.ms   = (stage_d.sf == mahd_pkg::SF_RESERVED) ? 7'd0
                 : mahd_pkg::MS_TABLE[stage_d.li][ms_col];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

>>> hw/rtl/mahd_alloc.sv
module mahd_alloc (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  mahd_pkg::lookup_t      stage_i,
  output logic                   valid_o,
  output mahd_pkg::alloc_t       stage_o
);

  logic             valid_q;
  mahd_pkg::alloc_t stage_d;
  mahd_pkg::alloc_t stage_q;
  logic [8:0]       per_ch;
  logic             cls48;
  logic             cls32;
  logic             joint;
  logic             layer2;

  always_comb begin
    per_ch = (stage_i.mode == mahd_pkg::MODE_MONO) ? stage_i.kbps : (stage_i.kbps >> 1);
    cls48  = stage_i.ver && (stage_i.sf == mahd_pkg::SF_48K);
    cls32  = stage_i.ver && (stage_i.sf == mahd_pkg::SF_32K);
    joint  = (stage_i.mode == mahd_pkg::MODE_JOINT);
    layer2 = (stage_i.li == mahd_pkg::LI_LAYER2);

    stage_d.hdr_ok = stage_i.hdr_ok;
    stage_d.kbps   = stage_i.kbps;
    stage_d.hz     = stage_i.hz;
    stage_d.ms     = stage_i.ms;
    stage_d.limit  = mahd_pkg::FULL_SUBBANDS;
    stage_d.sel    = mahd_pkg::ALLOC_SEL_A;
    stage_d.base   = 4'd0;

    if (joint || layer2) begin
      if ((cls48 && per_ch >= 9'd56) || (per_ch >= 9'd56 && per_ch <= 9'd80)) begin
        stage_d.limit = 6'd27;
      end else if (!cls48 && per_ch >= 9'd96) begin
        stage_d.limit = 6'd30;
        stage_d.sel   = mahd_pkg::ALLOC_SEL_B;
      end else if (!cls32 && per_ch <= 9'd48) begin
        stage_d.limit = 6'd8;
        stage_d.sel   = mahd_pkg::ALLOC_SEL_C;
        stage_d.base  = mahd_pkg::ALLOC_BASE_LOW;
      end else begin
        stage_d.limit = 6'd12;
        stage_d.sel   = mahd_pkg::ALLOC_SEL_C;
        stage_d.base  = mahd_pkg::ALLOC_BASE_LOW;
      end
    end

    if (joint) begin
      stage_d.bound = mahd_pkg::BOUND_TABLE[stage_i.li][stage_i.mext];
    end else if (layer2) begin
      stage_d.bound = stage_d.limit;
    end else begin
      stage_d.bound = mahd_pkg::FULL_SUBBANDS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

>>> hw/rtl/mpeg_audio_header_decoder_core.sv
// an accepted word passes the lookup, alloc and output registers in turn on its way to the outputs
// throughput: one word per cycle while the output is not stalled, the three register stages advance together
// a stalled output holds every stage, nothing is dropped or repeated
// reset clears the stage valid bits only, payload registers are not reset
module mpeg_audio_header_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] header_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        header_valid_o,
  output logic [8:0]  bitrate_kbps_o,
  output logic [15:0] sample_rate_hz_o,
  output logic [6:0]  frame_time_ms_o,
  output logic [5:0]  subband_limit_o,
  output logic [5:0]  stereo_bound_o,
  output logic [1:0]  alloc_table_select_o,
  output logic [3:0]  alloc_table_base_o
);

  logic              en;
  logic              s1_valid;
  mahd_pkg::lookup_t s1_stage;
  logic              s2_valid;
  mahd_pkg::alloc_t  s2_stage;
  logic              out_valid_q;
  mahd_pkg::alloc_t  out_d;
  mahd_pkg::alloc_t  out_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  mahd_lookup u_lookup (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_valid_i),
    .header_word_i (header_word_i),
    .valid_o       (s1_valid),
    .stage_o       (s1_stage)
  );

  mahd_alloc u_alloc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid),
    .stage_i (s1_stage),
    .valid_o (s2_valid),
    .stage_o (s2_stage)
  );

  // reserved layer zeroes the whole word
  always_comb begin
    out_d = s2_stage.hdr_ok ? s2_stage : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign header_valid_o       = out_q.hdr_ok;
  assign bitrate_kbps_o       = out_q.kbps;
  assign sample_rate_hz_o     = out_q.hz;
  assign frame_time_ms_o      = out_q.ms;
  assign subband_limit_o      = out_q.limit;
  assign stereo_bound_o       = out_q.bound;
  assign alloc_table_select_o = out_q.sel;
  assign alloc_table_base_o   = out_q.base;

endmodule

>>> hw/rtl/mahd_checker.sv
`include "assert_macros.svh"

module mahd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] header_word_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        header_valid_o,
  input logic [8:0]  bitrate_kbps_o,
  input logic [15:0] sample_rate_hz_o,
  input logic [6:0]  frame_time_ms_o,
  input logic [5:0]  subband_limit_o,
  input logic [5:0]  stereo_bound_o,
  input logic [1:0]  alloc_table_select_o,
  input logic [3:0]  alloc_table_base_o
);

  logic fields_nonzero;
  logic limit_legal;
  logic sel_low;
  logic base_low;

  assign fields_nonzero = (bitrate_kbps_o != 9'd0) || (sample_rate_hz_o != 16'd0)
                       || (frame_time_ms_o != 7'd0) || (subband_limit_o != 6'd0)
                       || (stereo_bound_o != 6'd0) || (alloc_table_select_o != 2'd0)
                       || (alloc_table_base_o != 4'd0);
  assign limit_legal = (subband_limit_o == 6'd8) || (subband_limit_o == 6'd12)
                    || (subband_limit_o == 6'd27) || (subband_limit_o == 6'd30)
                    || (subband_limit_o == 6'd32);
  assign sel_low  = (alloc_table_select_o == mahd_pkg::ALLOC_SEL_C);
  assign base_low = (alloc_table_base_o == mahd_pkg::ALLOC_BASE_LOW);

  `ASSERT_CLK(a_out_held, out_valid_o && out_stall_i |=> out_valid_o)
  `ASSERT_NEVER(a_reserved_zero, out_valid_o && !header_valid_o && fields_nonzero)
  `ASSERT_CLK(a_limit_legal, out_valid_o && header_valid_o |-> limit_legal)
  `ASSERT_CLK(a_base_follows_sel, out_valid_o |-> (sel_low == base_low))
  `ASSERT_CLK(a_in_held, in_valid_i && in_stall_o |=> in_valid_i && $stable(header_word_i))

endmodule

bind mpeg_audio_header_decoder_core mahd_checker u_mahd_checker (.*);
